>>> hdl/vpwd_pkg.sv
// vpwd_pkg: shared widths, constants and types for the velocity frame to wheel drive block.
// No dependencies; every other file in hdl/ but vpwd_checker refers to it by scoped names.
package vpwd_pkg;

    localparam int BYTE_W        = 8;
    localparam int SEP_W         = 11;
    localparam int RAD_W         = 9;
    localparam int MAX_W         = 6;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int PWM_W         = 8;

    localparam int PAYLOAD_DEPTH = 4;
    localparam int PD_IDX_W      = $clog2(PAYLOAD_DEPTH);

    // 2000*255 and 2047*255 both fit in 19 bits; their sum or difference in 20.
    localparam int PROD_W        = 19;
    localparam int MAG_W         = 20;
    localparam int NUM_W         = MAG_W + 1;
    // 200 * 511 fits in 17 bits
    localparam int DVS_W         = 17;

    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'hFF;
    localparam int                LIN_SCALE  = 2000;
    localparam int                RAD_SCALE  = 200;
    localparam logic [PWM_W-1:0]  PWM_FULL   = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_SEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] node_id;
        logic [SEP_W-1:0]  wheel_sep;
        logic [RAD_W-1:0]  wheel_rad;
        logic [MAX_W-1:0]  max_speed;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] lin_sign;
        logic [BYTE_W-1:0] lin_mag;
        logic [BYTE_W-1:0] ang_sign;
        logic [BYTE_W-1:0] ang_mag;
    } payload_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic             r_in1;
        logic             r_in2;
        logic [PWM_W-1:0] r_pwm;
        logic             l_in1;
        logic             l_in2;
        logic [PWM_W-1:0] l_pwm;
    } drive_t;

endpackage

>>> hdl/vpwd_front.sv
// vpwd_front: byte-wise frame parser (sync, sync, id, length, payload).
// Depends on vpwd_pkg.
module vpwd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          byte_valid,
    input  logic [vpwd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [vpwd_pkg::BYTE_W-1:0]   node_id,
    output logic                          frame_done,
    output vpwd_pkg::payload_t            frame_payload
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_ID,
        PH_LEN,
        PH_DATA
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [vpwd_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [vpwd_pkg::BYTE_W-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [vpwd_pkg::BYTE_W-1:0] store_reg  [vpwd_pkg::PAYLOAD_DEPTH];
    logic [vpwd_pkg::BYTE_W-1:0] store_next [vpwd_pkg::PAYLOAD_DEPTH];

    assign cnt_inc = cnt_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        store_next = store_reg;
        frame_done = 1'b0;
        if (byte_valid)
        begin
            unique case (phase_reg)
                PH_SYNC2:
                    phase_next = (rx_byte == vpwd_pkg::SYNC_BYTE) ? PH_ID : PH_SYNC1;
                PH_ID:
                    phase_next = (rx_byte == node_id) ? PH_LEN : PH_SYNC1;
                PH_LEN:
                begin
                    len_next   = rx_byte;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (cnt_reg < 8'(vpwd_pkg::PAYLOAD_DEPTH))
                        store_next[cnt_reg[vpwd_pkg::PD_IDX_W-1:0]] = rx_byte;
                    cnt_next = cnt_inc;
                    // 8-bit count wraps: a length of zero ends after 256 bytes
                    if (cnt_inc == len_reg)
                    begin
                        frame_done = 1'b1;
                        cnt_next   = '0;
                        phase_next = PH_SYNC1;
                    end
                end
                default:
                    phase_next = (rx_byte == vpwd_pkg::SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
            endcase
        end
    end

    // payload as it stands after this byte, so the last byte is included
    assign frame_payload.lin_sign = store_next[0];
    assign frame_payload.lin_mag  = store_next[1];
    assign frame_payload.ang_sign = store_next[2];
    assign frame_payload.ang_mag  = store_next[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            len_reg   <= '0;
            cnt_reg   <= '0;
            for (int i = 0; i < vpwd_pkg::PAYLOAD_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            store_reg <= store_next;
        end
    end

endmodule

>>> hdl/vpwd_fifo.sv
// vpwd_fifo: short queue of decoded payloads between the parser and the drive sequencer.
// Depends on vpwd_pkg.
module vpwd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  vpwd_pkg::payload_t    wr_data,
    input  logic                  rd_en,
    output vpwd_pkg::payload_t    rd_data,
    output vpwd_pkg::q_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vpwd_pkg::payload_t mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hdl/vpwd_div.sv
// vpwd_div: restoring divider, one quotient bit per cycle, shared by both wheels.
// Depends on vpwd_pkg.
module vpwd_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vpwd_pkg::MAG_W-1:0]    dividend,
    input  logic [vpwd_pkg::DVS_W-1:0]    divisor,
    output vpwd_pkg::div_status_t         status,
    output logic [vpwd_pkg::MAG_W-1:0]    quotient
);

    localparam int MAG_W = vpwd_pkg::MAG_W;
    localparam int DVS_W = vpwd_pkg::DVS_W;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DVS_W:0]   rem_shift;
    logic [DVS_W:0]   rem_diff;
    logic             ge;

    // dividend bits leave quo_reg at the top while quotient bits enter at the bottom
    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign ge        = (rem_shift >= {1'b0, dvs_reg});

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MAG_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[MAG_W-2:0], ge};
            rem_reg <= ge ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

endmodule

>>> hdl/vpwd_back.sv
// vpwd_back: wheel-speed sequencer; numerators, up to two divisions per wheel, output register.
// Depends on vpwd_pkg and vpwd_div.
module vpwd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vpwd_pkg::cfg_t        cfg,
    input  vpwd_pkg::q_status_t   q_status,
    input  vpwd_pkg::payload_t    q_data,
    output logic                  q_pop,
    output logic                  res_valid,
    output vpwd_pkg::drive_t      res,
    input  logic                  res_pop
);

    localparam int MAG_W  = vpwd_pkg::MAG_W;
    localparam int NUM_W  = vpwd_pkg::NUM_W;
    localparam int PROD_W = vpwd_pkg::PROD_W;
    localparam int DVS_W  = vpwd_pkg::DVS_W;
    localparam int MAX_W  = vpwd_pkg::MAX_W;
    localparam int PWM_W  = vpwd_pkg::PWM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_D1_GO,
        S_D1_WAIT,
        S_D2_GO,
        S_D2_WAIT,
        S_OUT
    } state_t;

    state_t                 state_reg;
    logic [MAG_W-1:0]       mag_reg [2];
    logic                   fwd_reg [2];
    logic [PWM_W-1:0]       pwm_reg [2];
    logic                   sel_reg;
    logic [MAX_W-1:0]       whole_reg;
    logic                   out_valid_reg;
    vpwd_pkg::drive_t       out_reg;
    logic                   out_load;

    logic [PROD_W-1:0]      lin_prod, ang_prod;
    logic signed [NUM_W-1:0] lin_term, ang_term, num_r, num_l;
    logic [NUM_W-1:0]       abs_r, abs_l;
    logic [vpwd_pkg::RAD_W-1:0] rad_eff;
    logic [MAX_W-1:0]       mx_eff;
    logic [DVS_W-1:0]       dvs_speed;

    logic                   div_start;
    logic [MAG_W-1:0]       div_dividend;
    logic [DVS_W-1:0]       div_divisor;
    vpwd_pkg::div_status_t  div_status;
    logic [MAG_W-1:0]       div_quotient;
    vpwd_pkg::drive_t       enc;

    // numerators straight from the queue head
    assign lin_prod = PROD_W'(q_data.lin_mag) * PROD_W'(vpwd_pkg::LIN_SCALE);
    assign ang_prod = PROD_W'(q_data.ang_mag) * PROD_W'(cfg.wheel_sep);
    assign lin_term = (q_data.lin_sign != '0) ? -$signed({2'b00, lin_prod})
                                              :  $signed({2'b00, lin_prod});
    assign ang_term = (q_data.ang_sign != '0) ? -$signed({2'b00, ang_prod})
                                              :  $signed({2'b00, ang_prod});
    assign num_r    = lin_term + ang_term;
    assign num_l    = lin_term - ang_term;
    assign abs_r    = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
    assign abs_l    = num_l[NUM_W-1] ? NUM_W'(-num_l) : NUM_W'(num_l);

    assign rad_eff   = (cfg.wheel_rad == '0) ? vpwd_pkg::RAD_W'(1) : cfg.wheel_rad;
    assign mx_eff    = (cfg.max_speed == '0) ? MAX_W'(1) : cfg.max_speed;
    assign dvs_speed = DVS_W'(rad_eff) * DVS_W'(vpwd_pkg::RAD_SCALE);

    assign q_pop     = (state_reg == S_IDLE) && !q_status.empty;
    assign div_start = (state_reg == S_D1_GO) || (state_reg == S_D2_GO);

    // result register takes a new value once the old one is gone or leaving
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || res_pop);

    always_comb
    begin
        if (state_reg == S_D2_GO)
        begin
            div_dividend = MAG_W'(whole_reg) * MAG_W'(vpwd_pkg::PWM_FULL);
            div_divisor  = DVS_W'(mx_eff);
        end
        else
        begin
            div_dividend = mag_reg[sel_reg];
            div_divisor  = dvs_speed;
        end
    end

    vpwd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // bridge levels; a forward command with zero duty brakes
    always_comb
    begin
        enc.r_pwm = pwm_reg[0];
        enc.l_pwm = pwm_reg[1];
        if (fwd_reg[0])
        begin
            enc.r_in1 = 1'b1;
            enc.r_in2 = (pwm_reg[0] == '0);
        end
        else
        begin
            enc.r_in1 = 1'b0;
            enc.r_in2 = 1'b1;
        end
        if (fwd_reg[1])
        begin
            enc.l_in1 = (pwm_reg[1] == '0);
            enc.l_in2 = 1'b1;
        end
        else
        begin
            enc.l_in1 = 1'b1;
            enc.l_in2 = 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (res_pop)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        mag_reg[0] <= abs_r[MAG_W-1:0];
                        mag_reg[1] <= abs_l[MAG_W-1:0];
                        fwd_reg[0] <= !num_r[NUM_W-1];
                        fwd_reg[1] <= !num_l[NUM_W-1];
                        sel_reg    <= 1'b0;
                        state_reg  <= S_D1_GO;
                    end
                end
                S_D1_GO:
                    state_reg <= S_D1_WAIT;
                S_D1_WAIT:
                begin
                    if (div_status.done)
                    begin
                        // whole >= max already gives at least full duty
                        if (div_quotient >= MAG_W'(mx_eff))
                        begin
                            pwm_reg[sel_reg] <= vpwd_pkg::PWM_FULL;
                            sel_reg          <= 1'b1;
                            state_reg        <= sel_reg ? S_OUT : S_D1_GO;
                        end
                        else
                        begin
                            whole_reg <= div_quotient[MAX_W-1:0];
                            state_reg <= S_D2_GO;
                        end
                    end
                end
                S_D2_GO:
                    state_reg <= S_D2_WAIT;
                S_D2_WAIT:
                begin
                    if (div_status.done)
                    begin
                        pwm_reg[sel_reg] <= div_quotient[PWM_W-1:0];
                        sel_reg          <= 1'b1;
                        state_reg        <= sel_reg ? S_OUT : S_D1_GO;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        out_reg   <= enc;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/velocity_packet_to_wheel_drive.sv
// velocity_packet_to_wheel_drive: top level, configuration registers and wiring.
// Depends on vpwd_pkg, vpwd_front, vpwd_fifo, vpwd_back (and vpwd_div below it).
//
// Bytes from a serial receiver go in on push/rx_byte; each is taken in the cycle it is
// pushed while full is low. A frame is FF, FF, node_id, length L, then L payload bytes
// (L = 0 means 256); only the first four payload bytes count, read as linear
// sign/magnitude in cm/s and angular sign/magnitude in 0.01 rad/s. Every completed
// frame yields one drive result on the output queue (empty/pop): bridge levels and an
// 8-bit duty per wheel, duty = floor(|wheel speed|) * 255 / max_wheel_speed, clipped
// at 255. Frames go into a QUEUE_DEPTH-entry queue; the drive sequencer then takes
// each frame through a numerator step, then per wheel a speed division and, unless
// the duty clips, a duty division on the single shared bit-serial divider (launch, 20
// quotient bits, hand-back), and a last step to post the result. A result left waiting
// on the output holds the sequencer in its last step. full rises only while that
// queue holds QUEUE_DEPTH frames.
// Registers: index 0 node_id, 1 wheel_separation_mm, 2 wheel_radius_mm,
// 3 max_wheel_speed; write them only while the block is idle.
module velocity_packet_to_wheel_drive #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte input
    input  logic                              push,
    output logic                              full,
    input  logic [vpwd_pkg::BYTE_W-1:0]       rx_byte,
    // drive results
    output logic                              empty,
    input  logic                              pop,
    output logic                              right_in1,
    output logic                              right_in2,
    output logic [vpwd_pkg::PWM_W-1:0]        right_pwm,
    output logic                              left_in1,
    output logic                              left_in2,
    output logic [vpwd_pkg::PWM_W-1:0]        left_pwm,
    // configuration writes
    input  logic                              cfg_we,
    input  logic [vpwd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vpwd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vpwd_pkg::cfg_t       cfg_reg;
    vpwd_pkg::q_status_t  q_status;
    vpwd_pkg::payload_t   frame_payload, q_data;
    vpwd_pkg::drive_t     res;
    logic                 byte_take;
    logic                 frame_done;
    logic                 q_pop;
    logic                 res_valid;

    // register file; reset values match the nominal chassis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id   <= 8'd1;
            cfg_reg.wheel_sep <= 11'd342;
            cfg_reg.wheel_rad <= 9'd75;
            cfg_reg.max_speed <= 6'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vpwd_pkg::REG_NODE_ID:
                    cfg_reg.node_id   <= cfg_data[vpwd_pkg::BYTE_W-1:0];
                vpwd_pkg::REG_WHEEL_SEP:
                    cfg_reg.wheel_sep <= cfg_data[vpwd_pkg::SEP_W-1:0];
                vpwd_pkg::REG_WHEEL_RAD:
                    cfg_reg.wheel_rad <= cfg_data[vpwd_pkg::RAD_W-1:0];
                vpwd_pkg::REG_MAX_SPEED:
                    cfg_reg.max_speed <= cfg_data[vpwd_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    // the parser stalls only when the frame queue is full
    assign full      = q_status.full;
    assign byte_take = push && !q_status.full;

    vpwd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_take),
        .rx_byte       (rx_byte),
        .node_id       (cfg_reg.node_id),
        .frame_done    (frame_done),
        .frame_payload (frame_payload)
    );

    vpwd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_done),
        .wr_data (frame_payload),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    vpwd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_pop   (pop)
    );

    // result side
    assign empty     = !res_valid;
    assign right_in1 = res.r_in1;
    assign right_in2 = res.r_in2;
    assign right_pwm = res.r_pwm;
    assign left_in1  = res.l_in1;
    assign left_in2  = res.l_in2;
    assign left_pwm  = res.l_pwm;

endmodule

>>> hdl/vpwd_checker.sv
// vpwd_checker: port-level assertions for velocity_packet_to_wheel_drive, plus its bind.
// Depends on the top level's ports only.
module vpwd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       right_in1,
    input logic       right_in2,
    input logic [7:0] right_pwm,
    input logic       left_in1,
    input logic       left_in2,
    input logic [7:0] left_pwm
);

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({right_in1, right_in2, right_pwm,
                                                 left_in1, left_in2, left_pwm})))
        else $error("result changed while waiting");

    // a result leaves only when taken
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result vanished without pop");

    // braking levels only with zero duty
    a_brake: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && ((right_in1 && right_in2) || (left_in1 && left_in2)))
            |-> ((!(right_in1 && right_in2) || right_pwm == 8'd0) &&
                 (!(left_in1 && left_in2) || left_pwm == 8'd0)))
        else $error("brake with nonzero duty");

    // bridges are never both low while a result waits
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((right_in1 || right_in2) && (left_in1 || left_in2)))
        else $error("bridge left floating");

endmodule

bind velocity_packet_to_wheel_drive vpwd_checker u_vpwd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .right_in1 (right_in1),
    .right_in2 (right_in2),
    .right_pwm (right_pwm),
    .left_in1  (left_in1),
    .left_in2  (left_in2),
    .left_pwm  (left_pwm)
);
